// ===== design/bba_pkg.sv =====
// Shared types, constants and helper functions of the buddy block allocator.
package bba_pkg;

    // Heap geometry.
    localparam int BLOCK_BYTES = 64;
    localparam int TOP_ORDER   = 10;
    localparam int BB_SH       = $clog2(BLOCK_BYTES);

    // Free-bit storage: 32-bit rows, each order packed into its own rows.
    localparam int WORD_W  = 32;
    localparam int WORD_SH = 5;
    localparam int BIT_W   = WORD_SH;
    localparam int ORD_W   = 6;
    localparam int BLK_W   = (TOP_ORDER > 0) ? TOP_ORDER : 1;

    // Number of rows one order occupies.
    function automatic int rows_const(input int o);
        if (TOP_ORDER - o >= WORD_SH) begin
            return 1 << (TOP_ORDER - o - WORD_SH);
        end
        return 1;
    endfunction

    function automatic int depth_const();
        int s;
        s = 0;
        for (int o = 0; o <= TOP_ORDER; o++) begin
            s = s + rows_const(o);
        end
        return s;
    endfunction

    localparam int DEPTH = depth_const();
    localparam int ROW_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Row count of an order chosen at run time.
    function automatic logic [ROW_W-1:0] rows_at(input logic [ORD_W-1:0] o);
        logic [ORD_W:0] d;
        d = (ORD_W+1)'(TOP_ORDER) - {1'b0, o};
        if (d >= (ORD_W+1)'(WORD_SH)) begin
            return ROW_W'(1) << (d - (ORD_W+1)'(WORD_SH));
        end
        return ROW_W'(1);
    endfunction

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes.
    localparam logic STAT_DONE = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] byte_count;
        logic [63:0] release_address;
    } t_in_word;

    typedef struct packed {
        logic [63:0] granted_address;
        logic        status;
    } t_out_word;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_WALK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SPLIT,
        ST_SPLIT_RD,
        ST_SPLIT_WR,
        ST_MERGE,
        ST_MERGE_WR,
        ST_DONE
    } t_state;

endpackage

// ===== design/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: ports, register, output word, checks.
//
// One request word enters on the input channel (allocate or free) and one
// result word leaves on the output channel for every request. A word is taken
// when valid is high and stall is low. The input stalls while a request is in
// progress, so one request is worked on at a time; the finished result sits in
// the output register while the next request is accepted.
// The free bits live in one memory of 32-bit rows, one bit per block per order.
// A request is first decoded; an allocate then scans rows for a free block
// (up to DEPTH rows in the worst case, 68 rows at the default size) and
// splits it down with a read and a write per split, while a free merges
// upward with a read and a write per merge level, all through the
// single memory port.
// After reset a clearing pass writes every row of the memory (DEPTH rows,
// 68 at the default size), during which no request is accepted; the base
// address register resets to zero and can be written over the APB port at any
// time the block is idle. A stalled result holds; the engine waits in its
// final state until the output register frees up.
module buddy_block_allocator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bba_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bba_pkg::t_out_word  o_out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    logic [63:0]         r_base;
    logic                r_out_valid;
    bba_pkg::t_out_word  r_out_word;
    bba_pkg::t_core_stat stat;
    bba_pkg::t_out_word  res;
    logic                out_free;
    logic                in_take;

    assign out_free = !r_out_valid || !i_out_stall;
    assign in_take  = i_in_valid && stat.idle;

    bba_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_take),
        .i_req      (i_in_word),
        .i_base     (r_base),
        .i_out_free (out_free),
        .o_stat     (stat),
        .o_res      (res)
    );

    // Base address register; the heap has a single register at offset zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
            r_base <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = r_base;

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stat.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.done) begin
            r_out_word <= res;
        end
    end

    assign o_in_stall  = !stat.idle;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // An accepted request blocks the input until it completes.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a request was taken");

    // A failed allocate reports a zero address.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == bba_pkg::STAT_FAIL)
            |-> (o_out_word.granted_address == 64'd0))
        else $error("failure with nonzero address");

    // A result is only loaded when the output register can take it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !stat.done)
        else $error("result overwrote a stalled word");

endmodule

// ===== design/bba_ram.sv =====
// Generic single-port RAM with registered read data.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port share one address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bba_core.sv =====
// Allocation engine: sequencer over the free-bit memory.
module bba_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  bba_pkg::t_in_word   i_req,
    input  logic [63:0]         i_base,
    input  logic                i_out_free,
    output bba_pkg::t_core_stat o_stat,
    output bba_pkg::t_out_word  o_res
);

    localparam int RW = bba_pkg::ROW_W;

    bba_pkg::t_state r_state, n_state;

    logic                      r_cmd;
    logic [31:0]               r_bytes;
    logic [63:0]               r_addr;
    logic [bba_pkg::ORD_W-1:0] r_want;
    logic [bba_pkg::ORD_W-1:0] r_cur;
    logic [RW-1:0]             r_rowbase;
    logic [RW-1:0]             r_off;
    logic [bba_pkg::BLK_W-1:0] r_blk;
    logic [RW-1:0]             r_clr;
    bba_pkg::t_out_word        r_res;

    // Memory port.
    logic                        ram_we;
    logic [RW-1:0]               ram_addr;
    logic [bba_pkg::WORD_W-1:0]  ram_wdata;
    logic [bba_pkg::WORD_W-1:0]  ram_rdata;

    bba_ram #(
        .WIDTH (bba_pkg::WORD_W),
        .DEPTH (bba_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Request decode: order needed and block index of a release.
    logic [32:0]               nblk;
    logic [32:0]               nm1;
    logic [bba_pkg::ORD_W-1:0] want_c;
    logic [63:0]               diff;
    logic [bba_pkg::ORD_W:0]   sh;
    logic [bba_pkg::BLK_W-1:0] rel_blk;
    logic                      rel_ok;
    logic                      too_big;

    always_comb begin
        nblk = 33'(r_bytes >> bba_pkg::BB_SH)
             + 33'(|(r_bytes & 32'(bba_pkg::BLOCK_BYTES - 1)));
        nm1  = (nblk == 33'd0) ? 33'd0 : nblk - 33'd1;
        want_c = '0;
        for (int i = 0; i < 33; i++) begin
            if (nm1[i]) begin
                want_c = bba_pkg::ORD_W'(i + 1);
            end
        end
        too_big = want_c > bba_pkg::ORD_W'(bba_pkg::TOP_ORDER);
        diff    = r_addr - i_base;
        sh      = (bba_pkg::ORD_W+1)'(bba_pkg::BB_SH) + {1'b0, want_c};
        rel_blk = bba_pkg::BLK_W'(diff >> sh);
        rel_ok  = (diff >> (bba_pkg::BB_SH + bba_pkg::TOP_ORDER)) == 64'd0;
    end

    // Lowest set bit of the row just read.
    logic [bba_pkg::BIT_W-1:0] low_bit;
    always_comb begin
        low_bit = '0;
        for (int i = bba_pkg::WORD_W - 1; i >= 0; i--) begin
            if (ram_rdata[i]) begin
                low_bit = bba_pkg::BIT_W'(i);
            end
        end
    end

    // Row and bit positions of the current block, its buddy and the split target.
    logic [bba_pkg::BLK_W-1:0] buddy;
    logic [bba_pkg::BLK_W-1:0] tgt;
    logic [RW-1:0]             blk_row;
    logic [RW-1:0]             tgt_row;
    logic [bba_pkg::BIT_W-1:0] blk_bit;
    logic [bba_pkg::BIT_W-1:0] bud_bit;
    logic [bba_pkg::BIT_W-1:0] tgt_bit;
    logic                      at_top;
    logic                      last_row;
    logic                      bud_free;

    always_comb begin
        buddy    = r_blk ^ bba_pkg::BLK_W'(1);
        tgt      = r_blk | bba_pkg::BLK_W'(1);
        blk_row  = r_rowbase + RW'(r_blk >> bba_pkg::WORD_SH);
        tgt_row  = r_rowbase + RW'(tgt >> bba_pkg::WORD_SH);
        blk_bit  = bba_pkg::BIT_W'(r_blk);
        bud_bit  = bba_pkg::BIT_W'(buddy);
        tgt_bit  = bba_pkg::BIT_W'(tgt);
        at_top   = r_cur == bba_pkg::ORD_W'(bba_pkg::TOP_ORDER);
        last_row = (r_off + RW'(1)) == bba_pkg::rows_at(r_cur);
        bud_free = !at_top && ram_rdata[bud_bit];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            bba_pkg::ST_CLEAR: begin
                if (r_clr == RW'(bba_pkg::DEPTH - 1)) n_state = bba_pkg::ST_IDLE;
            end
            bba_pkg::ST_IDLE: begin
                if (i_start) n_state = bba_pkg::ST_DECODE;
            end
            bba_pkg::ST_DECODE: begin
                if (too_big || (r_cmd == bba_pkg::CMD_FREE && !rel_ok)) begin
                    n_state = bba_pkg::ST_DONE;
                end else begin
                    n_state = bba_pkg::ST_WALK;
                end
            end
            bba_pkg::ST_WALK: begin
                if (r_cur == r_want) begin
                    n_state = (r_cmd == bba_pkg::CMD_ALLOC) ? bba_pkg::ST_SCAN_RD
                                                            : bba_pkg::ST_MERGE;
                end
            end
            bba_pkg::ST_SCAN_RD:  n_state = bba_pkg::ST_SCAN_CHK;
            bba_pkg::ST_SCAN_CHK: begin
                if (|ram_rdata) begin
                    n_state = bba_pkg::ST_SPLIT;
                end else if (last_row && at_top) begin
                    n_state = bba_pkg::ST_DONE;
                end else begin
                    n_state = bba_pkg::ST_SCAN_RD;
                end
            end
            bba_pkg::ST_SPLIT: begin
                n_state = (r_cur > r_want) ? bba_pkg::ST_SPLIT_RD : bba_pkg::ST_DONE;
            end
            bba_pkg::ST_SPLIT_RD: n_state = bba_pkg::ST_SPLIT_WR;
            bba_pkg::ST_SPLIT_WR: n_state = bba_pkg::ST_SPLIT;
            bba_pkg::ST_MERGE:    n_state = bba_pkg::ST_MERGE_WR;
            bba_pkg::ST_MERGE_WR: n_state = bud_free ? bba_pkg::ST_MERGE : bba_pkg::ST_DONE;
            bba_pkg::ST_DONE: begin
                if (i_out_free) n_state = bba_pkg::ST_IDLE;
            end
            default: n_state = bba_pkg::ST_IDLE;
        endcase
    end

    // Memory port and status outputs.
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = blk_row;
        ram_wdata = ram_rdata;
        case (r_state)
            bba_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = (r_clr == RW'(bba_pkg::DEPTH - 1))
                          ? bba_pkg::WORD_W'(1) : '0;
            end
            bba_pkg::ST_SCAN_RD: ram_addr = r_rowbase + r_off;
            bba_pkg::ST_SCAN_CHK: begin
                ram_addr = r_rowbase + r_off;
                ram_we   = |ram_rdata;
                ram_wdata[low_bit] = 1'b0;
            end
            bba_pkg::ST_SPLIT_RD: ram_addr = tgt_row;
            bba_pkg::ST_SPLIT_WR: begin
                ram_addr = tgt_row;
                ram_we   = 1'b1;
                ram_wdata[tgt_bit] = 1'b1;
            end
            bba_pkg::ST_MERGE: ram_addr = blk_row;
            bba_pkg::ST_MERGE_WR: begin
                ram_addr = blk_row;
                ram_we   = 1'b1;
                if (bud_free) begin
                    ram_wdata[bud_bit] = 1'b0;
                end else begin
                    ram_wdata[blk_bit] = 1'b1;
                end
            end
            default: ram_we = 1'b0;
        endcase
        o_stat.idle = r_state == bba_pkg::ST_IDLE;
        o_stat.done = (r_state == bba_pkg::ST_DONE) && i_out_free;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == bba_pkg::ST_CLEAR) r_clr <= r_clr + RW'(1);
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            bba_pkg::ST_IDLE: begin
                r_cmd   <= i_req.command;
                r_bytes <= i_req.byte_count;
                r_addr  <= i_req.release_address;
            end
            bba_pkg::ST_DECODE: begin
                r_want    <= want_c;
                r_cur     <= '0;
                r_rowbase <= '0;
                r_off     <= '0;
                r_blk     <= rel_blk;
                r_res.granted_address <= '0;
                r_res.status <= (r_cmd == bba_pkg::CMD_ALLOC && too_big)
                              ? bba_pkg::STAT_FAIL : bba_pkg::STAT_DONE;
            end
            bba_pkg::ST_WALK: begin
                if (r_cur != r_want) begin
                    r_rowbase <= r_rowbase + bba_pkg::rows_at(r_cur);
                    r_cur     <= r_cur + bba_pkg::ORD_W'(1);
                end
            end
            bba_pkg::ST_SCAN_CHK: begin
                if (|ram_rdata) begin
                    r_blk <= bba_pkg::BLK_W'({r_off, low_bit});
                end else if (!last_row) begin
                    r_off <= r_off + RW'(1);
                end else if (at_top) begin
                    r_res.status <= bba_pkg::STAT_FAIL;
                end else begin
                    r_off     <= '0;
                    r_rowbase <= r_rowbase + bba_pkg::rows_at(r_cur);
                    r_cur     <= r_cur + bba_pkg::ORD_W'(1);
                end
            end
            bba_pkg::ST_SPLIT: begin
                if (r_cur > r_want) begin
                    r_cur     <= r_cur - bba_pkg::ORD_W'(1);
                    r_rowbase <= r_rowbase - bba_pkg::rows_at(r_cur - bba_pkg::ORD_W'(1));
                    r_blk     <= r_blk << 1;
                end else begin
                    r_res.granted_address <= i_base
                        + (64'(r_blk) << ((bba_pkg::ORD_W+1)'(bba_pkg::BB_SH)
                                          + {1'b0, r_want}));
                end
            end
            bba_pkg::ST_MERGE_WR: begin
                if (bud_free) begin
                    r_blk     <= r_blk >> 1;
                    r_rowbase <= r_rowbase + bba_pkg::rows_at(r_cur);
                    r_cur     <= r_cur + bba_pkg::ORD_W'(1);
                end
            end
            default: r_cmd <= r_cmd;
        endcase
    end

    assign o_res = r_res;

endmodule

// ===== dv/bba_checker.sv =====
// Checker for the buddy block allocator: watches both channels, predicts and compares.
module bba_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  bba_pkg::t_in_word   i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  bba_pkg::t_out_word  i_out_word,
    input  logic                i_cfg_wr,
    input  logic [63:0]         i_cfg_base,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 2 << bba_pkg::TOP_ORDER;

    logic [63:0]        heap_base;
    logic               free_map [SLOTS];
    bba_pkg::t_out_word expected_q [$];
    int                 fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_q.size();

    function automatic int tree_slot(int ord, longint unsigned blk);
        return int'(((64'd1 << (bba_pkg::TOP_ORDER - ord)) + blk) & (SLOTS - 1));
    endfunction

    // Smallest order whose block count covers the byte count.
    function automatic int order_of(logic [31:0] bytes);
        longint unsigned nblk;
        int o;
        nblk = bytes / bba_pkg::BLOCK_BYTES + ((bytes % bba_pkg::BLOCK_BYTES) != 0);
        o = 0;
        while (o <= bba_pkg::TOP_ORDER && (64'd1 << o) < nblk) o++;
        return o;
    endfunction

    // Apply one request to the free map and return its result word.
    function automatic bba_pkg::t_out_word serve_request(bba_pkg::t_in_word w);
        bba_pkg::t_out_word r;
        int want, cur;
        longint unsigned blk;
        bit found;
        r = '0;
        want = order_of(w.byte_count);
        if (w.command == bba_pkg::CMD_ALLOC) begin
            if (want > bba_pkg::TOP_ORDER) begin
                r.status = bba_pkg::STAT_FAIL;
                return r;
            end
            found = 0;
            blk = 0;
            cur = want;
            while (cur <= bba_pkg::TOP_ORDER && !found) begin
                for (longint unsigned b = 0; b < (64'd1 << (bba_pkg::TOP_ORDER - cur));
                     b++) begin
                    if (free_map[tree_slot(cur, b)]) begin
                        blk = b;
                        found = 1;
                        break;
                    end
                end
                cur++;
            end
            if (!found) begin
                r.status = bba_pkg::STAT_FAIL;
                return r;
            end
            cur--;
            free_map[tree_slot(cur, blk)] = 0;
            while (cur > want) begin
                cur--;
                blk = blk * 2;
                free_map[tree_slot(cur, blk + 1)] = 1;
            end
            r.granted_address = heap_base + (blk << want) * bba_pkg::BLOCK_BYTES;
            r.status = bba_pkg::STAT_DONE;
        end else begin
            if (want > bba_pkg::TOP_ORDER) return r;
            blk = (w.release_address - heap_base) / (64'(bba_pkg::BLOCK_BYTES) << want);
            if (blk >= (64'd1 << (bba_pkg::TOP_ORDER - want))) return r;
            cur = want;
            while (cur < bba_pkg::TOP_ORDER) begin
                if (!free_map[tree_slot(cur, blk ^ 1)]) begin
                    free_map[tree_slot(cur, blk)] = 1;
                    return r;
                end
                free_map[tree_slot(cur, blk ^ 1)] = 0;
                blk = blk >> 1;
                cur++;
            end
            free_map[tree_slot(bba_pkg::TOP_ORDER, 0)] = 1;
        end
        return r;
    endfunction

    // Predict on accepted requests, compare on accepted results.
    always @(posedge i_clk) begin
        bba_pkg::t_out_word exp_word;
        if (!i_rst_n) begin
            heap_base = '0;
            foreach (free_map[i]) free_map[i] = 0;
            free_map[tree_slot(bba_pkg::TOP_ORDER, 0)] = 1;
            expected_q.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_wr) heap_base = i_cfg_base;
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result word %h", i_out_word);
                end else begin
                    exp_word = expected_q.pop_front();
                    if (exp_word.granted_address !== i_out_word.granted_address ||
                        exp_word.status !== i_out_word.status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch: expected addr %h status %b, got addr %h status %b",
                                     exp_word.granted_address, exp_word.status,
                                     i_out_word.granted_address, i_out_word.status);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(serve_request(i_in_word));
        end
    end
endmodule

// ===== dv/tb_buddy_block_allocator.sv =====
// Testbench top of the buddy block allocator: stimulus, configuration and verdict.
module tb_buddy_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_BYTES = bba_pkg::BLOCK_BYTES << bba_pkg::TOP_ORDER;
    localparam logic [2:0] REG_BASE = 3'd0;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid, in_stall, out_valid, out_stall;
    bba_pkg::t_in_word  in_word;
    bba_pkg::t_out_word out_word;
    logic               psel, penable, pwrite, pready;
    logic [2:0]         paddr;
    logic [63:0]        pwdata, prdata;
    int                 fail_count, pending;
    logic [63:0]        cur_base;
    logic [63:0]        live_addr [$];
    int                 live_bytes [$];

    buddy_block_allocator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_word(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    bba_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_word(out_word),
        .i_cfg_wr(psel && penable && pwrite && pready && paddr == REG_BASE),
        .i_cfg_base(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #40ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver stalls in phases: none, light, heavy.
    initial begin
        int mode;
        out_stall = 0;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 200)) begin
                @(posedge i_clk);
                case (mode)
                    0: out_stall <= 0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Send one word and wait until it is taken; bursts with random gaps.
    // Valid drops for one cycle after each word, while the block is still busy.
    int burst_left;
    task automatic send_word(logic cmd, logic [31:0] bytes, logic [63:0] addr);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
        end
        burst_left--;
        in_valid <= 1;
        in_word <= '{command: cmd, byte_count: bytes, release_address: addr};
        do @(posedge i_clk); while (in_stall);
        in_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic alloc_word(logic [31:0] bytes);
        send_word(bba_pkg::CMD_ALLOC, bytes, $urandom() ^ (64'($urandom()) << 32));
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // Free everything handed out; addresses come from the result channel.
    task automatic release_all();
        while (live_addr.size() != 0) begin
            send_word(bba_pkg::CMD_FREE, live_bytes[0], live_addr[0]);
            void'(live_addr.pop_front());
            void'(live_bytes.pop_front());
        end
    endtask

    task automatic write_base(logic [63:0] value);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= REG_BASE; pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        cur_base = value;
    endtask

    // Pair every result with its request and keep granted blocks for release.
    bba_pkg::t_in_word req_q [$];
    always @(posedge i_clk) begin
        bba_pkg::t_in_word req;
        if (i_rst_n && out_valid && !out_stall && req_q.size() != 0) begin
            req = req_q.pop_front();
            if (req.command == bba_pkg::CMD_ALLOC && out_word.status == bba_pkg::STAT_DONE) begin
                live_addr.push_back(out_word.granted_address);
                live_bytes.push_back(req.byte_count);
            end
        end
        if (i_rst_n && in_valid && !in_stall)
            req_q.push_back(in_word);
    end

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, HEAP_BYTES);
            default: return $urandom_range(0, 16 * bba_pkg::BLOCK_BYTES);
        endcase
    endfunction

    initial begin
        logic [63:0] bases [4];
        logic [63:0] a;
        int kind;
        in_valid = 0; in_word = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = REG_BASE; pwdata = '0;
        burst_left = 0;
        cur_base = 0;
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: zero bytes, whole heap, too large, odd sizes, bad frees.
        alloc_word(0);
        alloc_word(HEAP_BYTES);
        alloc_word(HEAP_BYTES + 1);
        alloc_word(32'hFFFF_FFFF);
        alloc_word(1);
        alloc_word(bba_pkg::BLOCK_BYTES + 1);
        alloc_word(3 * bba_pkg::BLOCK_BYTES);
        send_word(bba_pkg::CMD_FREE, 32'hFFFF_FFFF, 64'h0);
        send_word(bba_pkg::CMD_FREE, HEAP_BYTES + 1, 64'h0);
        send_word(bba_pkg::CMD_FREE, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(bba_pkg::CMD_FREE, 0, 64'(HEAP_BYTES));
        drain();
        release_all();
        send_word(bba_pkg::CMD_FREE, bba_pkg::BLOCK_BYTES, 64'd5);
        alloc_word(bba_pkg::BLOCK_BYTES);
        drain();
        release_all();
        drain();

        bases[0] = 64'hFFFF_FFFF_FFFF_0000;
        bases[1] = {$urandom(), $urandom()} & ~64'(bba_pkg::BLOCK_BYTES - 1);
        bases[2] = 64'hFFFF_FFFF_FFFF_FFC0;
        bases[3] = 64'h0;
        for (int ph = 0; ph < 4; ph++) begin
            write_base(bases[ph]);
            for (int n = 0; n < 450; n++) begin
                kind = $urandom_range(0, 9);
                if (kind < 5) begin
                    alloc_word(pick_size());
                end else if (kind < 8 && live_addr.size() != 0) begin
                    drain_free:
                    begin
                        int k;
                        k = $urandom_range(0, live_addr.size() - 1);
                        send_word(bba_pkg::CMD_FREE, live_bytes[k], live_addr[k]);
                        live_addr.delete(k);
                        live_bytes.delete(k);
                    end
                end else begin
                    a = (kind == 9) ? {$urandom(), $urandom()} :
                        cur_base + $urandom_range(0, 2 * HEAP_BYTES);
                    send_word(bba_pkg::CMD_FREE, pick_size(), a);
                end
            end
            drain();
            release_all();
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
design/bba_pkg.sv
design/bba_ram.sv
design/bba_core.sv
design/buddy_block_allocator.sv
dv/bba_checker.sv
dv/tb_buddy_block_allocator.sv
